[hdl/bqc_pkg.sv]
// Package for the biquad cascade: FSM state type, MAC control struct and
// coefficient word layout. Used by bqc_mac, biquad_cascade_df2t_gain and the testbench.
// No dependencies.
package bqc_pkg;

    // Coefficient words of one section, stored at stage*6 + word.
    localparam int             WORDS_PER_STAGE = 6;
    localparam logic [2:0]     W_B0   = 3'd0;
    localparam logic [2:0]     W_B1   = 3'd1;
    localparam logic [2:0]     W_B2   = 3'd2;
    localparam logic [2:0]     W_A1   = 3'd3;
    localparam logic [2:0]     W_A2   = 3'd4;
    localparam logic [2:0]     W_GAIN = 3'd5;

    // Configuration register indexes.
    localparam logic           CFG_NUM_STAGES  = 1'b0;
    localparam logic           CFG_GAIN_ENABLE = 1'b1;

    // Operation codes of an input transaction.
    localparam logic           OP_FILTER = 1'b0;
    localparam logic           OP_COEF   = 1'b1;

    // Each product is rounded to nearest, dropping this many fraction bits.
    localparam int             PSHIFT = 12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_MUL_B0,
        S_ACC_B0,
        S_ACC_B1,
        S_MUL_A1,
        S_ACC_A1,
        S_WR_D1,
        S_ACC_A2,
        S_WR_D2,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_D1,
        BASE_D2
    } t_base_sel;

    typedef struct packed {
        logic    mul_en;
        logic    mul_use_y;
        t_acc_op acc_op;
        logic    y_en;
    } t_mac_ctrl;

endpackage

[hdl/bqc_mac.sv]
// Shared multiply-accumulate unit of the biquad cascade: one registered
// multiplier, one accumulator, rounding and saturation of y, delay and gain.
// Depends on bqc_pkg.
module bqc_mac #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  logic                                          i_clk,
    input  bqc_pkg::t_mac_ctrl                            i_ctrl,
    input  logic signed [COEF_WIDTH-1:0]                  i_coef,
    input  logic signed [SAMPLE_WIDTH-1:0]                i_x,
    input  logic signed [SAMPLE_WIDTH+COEF_WIDTH-9:0]     i_base,
    output logic signed [SAMPLE_WIDTH-1:0]                o_y,
    output logic                                          o_y_clip,
    output logic signed [SAMPLE_WIDTH+COEF_WIDTH-9:0]     o_d,
    output logic                                          o_d_clip,
    output logic signed [SAMPLE_WIDTH-1:0]                o_g,
    output logic                                          o_g_clip
);
    import bqc_pkg::*;

    localparam int PW  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int RPW = PW - PSHIFT;
    localparam int DW  = SAMPLE_WIDTH + COEF_WIDTH - 8;
    localparam int AW  = DW + 2;
    localparam int YS  = COEF_WIDTH - 15;
    localparam int GS  = COEF_WIDTH - 3;
    localparam int YW  = AW - YS;
    localparam int GW  = PW - GS;

    localparam logic signed [PW-1:0] P_HALF = {{(PW-1){1'b0}}, 1'b1} << (PSHIFT - 1);
    localparam logic signed [AW-1:0] Y_HALF = {{(AW-1){1'b0}}, 1'b1} << (YS - 1);
    localparam logic signed [PW-1:0] G_HALF = {{(PW-1){1'b0}}, 1'b1} << (GS - 1);

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [DW-1:0]           D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0]           D_MIN = {1'b1, {(DW-1){1'b0}}};

    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_y;

    logic signed [SAMPLE_WIDTH-1:0] mul_op;
    logic signed [PW-1:0]           prod_half;
    logic signed [RPW-1:0]          prod_rnd;
    logic signed [AW-1:0]           acc_addend;
    logic signed [AW-1:0]           acc_sum;
    logic signed [AW-1:0]           y_half;
    logic signed [YW-1:0]           y_wide;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic signed [PW-1:0]           g_half;
    logic signed [GW-1:0]           g_wide;

    assign mul_op = i_ctrl.mul_use_y ? r_y : i_x;

    // Product rounded to the delay fraction.
    assign prod_half = r_prod + P_HALF;
    assign prod_rnd  = $signed(prod_half[PW-1:PSHIFT]);

    assign acc_addend = (i_ctrl.acc_op == ACC_ADD) ? r_acc : AW'(i_base);
    assign acc_sum    = acc_addend + AW'(prod_rnd);

    // Section output: round the accumulator to the sample format and clip.
    assign y_half = r_acc + Y_HALF;
    assign y_wide = $signed(y_half[AW-1:YS]);
    always_comb begin
        o_y_clip = !((&y_wide[YW-1:SAMPLE_WIDTH-1]) || !(|y_wide[YW-1:SAMPLE_WIDTH-1]));
        if (o_y_clip) begin
            y_sat = y_wide[YW-1] ? S_MIN : S_MAX;
        end else begin
            y_sat = y_wide[SAMPLE_WIDTH-1:0];
        end
    end

    // Delay value: clip the accumulator to the state width.
    always_comb begin
        o_d_clip = !((&r_acc[AW-1:DW-1]) || !(|r_acc[AW-1:DW-1]));
        if (o_d_clip) begin
            o_d = r_acc[AW-1] ? D_MIN : D_MAX;
        end else begin
            o_d = r_acc[DW-1:0];
        end
    end

    // Gain product back to the sample format.
    assign g_half = r_prod + G_HALF;
    assign g_wide = $signed(g_half[PW-1:GS]);
    always_comb begin
        o_g_clip = !((&g_wide[GW-1:SAMPLE_WIDTH-1]) || !(|g_wide[GW-1:SAMPLE_WIDTH-1]));
        if (o_g_clip) begin
            o_g = g_wide[GW-1] ? S_MIN : S_MAX;
        end else begin
            o_g = g_wide[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_y = r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= PW'(i_coef) * PW'(mul_op);
        end
        if (i_ctrl.acc_op != ACC_HOLD) begin
            r_acc <= acc_sum;
        end
        if (i_ctrl.y_en) begin
            r_y <= y_sat;
        end
    end

endmodule

[hdl/biquad_cascade_df2t_gain.sv]
// Top level of the biquad cascade (transposed direct form II, per-stage gain).
// Holds the sequencer, coefficient memory, delay registers and result register.
// Depends on bqc_pkg and bqc_mac.
//
//  channel   handshake                    payload
//  --------  ---------------------------  -------------------------------------------
//  input     i_in_valid / o_in_stall      i_op, i_sample_in, i_end_of_block,
//                                         i_coef_index, i_coef_value
//  output    o_out_valid / i_out_stall    o_sample_out, o_end_of_block_out, o_saturated
//  config    i_cfg_we                     i_cfg_index, i_cfg_wdata
//
// A coefficient write is stored as it is accepted; a sample runs through the N sections
// in use one after another on the single MAC. The input is stalled while a sample is in
// flight; a finished result waits in the output register, so the next transaction is
// taken while it is pending. Reset is synchronous: it clears the delay registers and
// output valid and sets one section, gain off; coefficients keep no reset.
module biquad_cascade_df2t_gain #(
    parameter int MAX_STAGES   = 8,
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_end_of_block,
    input  logic [5:0]                     i_coef_index,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_end_of_block_out,
    output logic                           o_saturated,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [3:0]                     i_cfg_wdata
);
    import bqc_pkg::*;

    localparam int NWORDS = WORDS_PER_STAGE * MAX_STAGES;
    localparam int CA_W   = $clog2(NWORDS);
    localparam int IW     = (CA_W > 6) ? CA_W : 6;
    localparam int SI_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int DW     = SAMPLE_WIDTH + COEF_WIDTH - 8;

    localparam logic [CA_W-1:0] STRIDE   = CA_W'(WORDS_PER_STAGE);
    localparam logic [IW-1:0]   NWORDS_I = IW'(NWORDS);
    localparam logic [4:0]      MAX_ST5  = 5'(MAX_STAGES);

    t_state                         r_state, n_state;
    logic [3:0]                     r_num_stages;
    logic                           r_gain_en;
    logic signed [COEF_WIDTH-1:0]   r_coef_mem [NWORDS];
    logic signed [COEF_WIDTH-1:0]   r_coef;
    logic signed [DW-1:0]           r_d1 [MAX_STAGES];
    logic signed [DW-1:0]           r_d2 [MAX_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_eob;
    logic                           r_clip;
    logic [SI_W-1:0]                r_stage;
    logic [CA_W-1:0]                r_base;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_eob;
    logic                           r_out_sat;

    logic                           in_accept;
    logic                           out_free;
    logic [IW-1:0]                  idx_ext;
    logic                           coef_we;
    logic [4:0]                     stages5;
    logic [4:0]                     last5;
    logic                           last_stage;

    t_mac_ctrl                      mac_ctrl;
    logic [2:0]                     word;
    logic                           next_base;
    t_base_sel                      base_sel;
    logic                           d1_we;
    logic                           d2_we;
    logic                           x_we;
    logic                           emit;
    logic                           clip_now;
    logic [CA_W-1:0]                rd_addr;
    logic signed [DW-1:0]           base;

    logic signed [SAMPLE_WIDTH-1:0] mac_y;
    logic                           mac_y_clip;
    logic signed [DW-1:0]           mac_d;
    logic                           mac_d_clip;
    logic signed [SAMPLE_WIDTH-1:0] mac_g;
    logic                           mac_g_clip;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign idx_ext = IW'(i_coef_index);
    assign coef_we = in_accept && (i_op == OP_COEF) && (idx_ext < NWORDS_I);

    // Sections in use: zero acts as one, anything above the build maximum as the maximum.
    always_comb begin
        stages5 = {1'b0, r_num_stages};
        if (stages5 == 5'd0) begin
            stages5 = 5'd1;
        end
        if (stages5 > MAX_ST5) begin
            stages5 = MAX_ST5;
        end
        last5 = stages5 - 5'd1;
    end
    assign last_stage = (r_stage == last5[SI_W-1:0]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_op == OP_FILTER)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH:  n_state = S_MUL_B0;
            S_MUL_B0: n_state = S_ACC_B0;
            S_ACC_B0: n_state = S_ACC_B1;
            S_ACC_B1: n_state = S_MUL_A1;
            S_MUL_A1: n_state = S_ACC_A1;
            S_ACC_A1: n_state = S_WR_D1;
            S_WR_D1:  n_state = S_ACC_A2;
            S_ACC_A2: n_state = S_WR_D2;
            S_WR_D2:  n_state = last_stage ? S_EMIT : S_MUL_B0;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs. A coefficient address is issued in the cycle before the
    // MAC uses the word, since the memory read is registered.
    always_comb begin
        mac_ctrl.mul_en    = 1'b0;
        mac_ctrl.mul_use_y = 1'b0;
        mac_ctrl.acc_op    = ACC_HOLD;
        mac_ctrl.y_en      = 1'b0;
        word      = W_B0;
        next_base = 1'b0;
        base_sel  = BASE_ZERO;
        d1_we     = 1'b0;
        d2_we     = 1'b0;
        x_we      = 1'b0;
        emit      = 1'b0;
        clip_now  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_FETCH: begin
                word = W_B0;
            end
            S_MUL_B0: begin
                mac_ctrl.mul_en = 1'b1;
                word = W_B1;
            end
            S_ACC_B0: begin
                mac_ctrl.acc_op = ACC_LOAD;
                base_sel        = BASE_D1;
                mac_ctrl.mul_en = 1'b1;
            end
            S_ACC_B1: begin
                mac_ctrl.y_en   = 1'b1;
                clip_now        = mac_y_clip;
                mac_ctrl.acc_op = ACC_LOAD;
                base_sel        = BASE_D2;
                word            = W_A1;
            end
            S_MUL_A1: begin
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.mul_use_y = 1'b1;
                word               = W_B2;
            end
            S_ACC_A1: begin
                mac_ctrl.acc_op = ACC_ADD;
                mac_ctrl.mul_en = 1'b1;
                word            = W_A2;
            end
            S_WR_D1: begin
                d1_we              = 1'b1;
                clip_now           = mac_d_clip;
                mac_ctrl.acc_op    = ACC_LOAD;
                base_sel           = BASE_ZERO;
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.mul_use_y = 1'b1;
                word               = W_GAIN;
            end
            S_ACC_A2: begin
                mac_ctrl.acc_op    = ACC_ADD;
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.mul_use_y = 1'b1;
            end
            S_WR_D2: begin
                d2_we     = 1'b1;
                x_we      = 1'b1;
                clip_now  = mac_d_clip || (r_gain_en && mac_g_clip);
                word      = W_B0;
                next_base = 1'b1;
            end
            S_EMIT: begin
                emit = out_free;
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = (next_base ? (r_base + STRIDE) : r_base) + CA_W'(word);

    always_comb begin
        unique case (base_sel)
            BASE_D1:   base = r_d1[r_stage];
            BASE_D2:   base = r_d2[r_stage];
            BASE_ZERO: base = '0;
            default:   base = '0;
        endcase
    end

    bqc_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_coef   (r_coef),
        .i_x      (r_x),
        .i_base   (base),
        .o_y      (mac_y),
        .o_y_clip (mac_y_clip),
        .o_d      (mac_d),
        .o_d_clip (mac_d_clip),
        .o_g      (mac_g),
        .o_g_clip (mac_g_clip)
    );

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[idx_ext[CA_W-1:0]] <= i_coef_value;
        end
        r_coef <= r_coef_mem[rd_addr];
    end

    // Control, configuration and delay state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_stages <= 4'd1;
            r_gain_en    <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NUM_STAGES:  r_num_stages <= i_cfg_wdata;
                    CFG_GAIN_ENABLE: r_gain_en    <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (d1_we) begin
                r_d1[r_stage] <= mac_d;
            end
            if (d2_we) begin
                r_d2[r_stage] <= mac_d;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-sample datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept && (i_op == OP_FILTER)) begin
            r_x     <= i_sample_in;
            r_eob   <= i_end_of_block;
            r_clip  <= 1'b0;
            r_stage <= '0;
            r_base  <= '0;
        end else begin
            r_clip <= r_clip || clip_now;
            if (x_we) begin
                // The next section sees the gain-scaled output when gain is on; the
                // delay update above already used the unscaled one.
                r_x     <= r_gain_en ? mac_g : mac_y;
                r_stage <= r_stage + SI_W'(1);
                r_base  <= r_base + STRIDE;
            end
        end
        if (emit) begin
            r_out_sample <= r_x;
            r_out_eob    <= r_eob;
            r_out_sat    <= r_clip;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sample_out       = r_out_sample;
    assign o_end_of_block_out = r_out_eob;
    assign o_saturated        = r_out_sat;

endmodule

[tb/biquad_cascade_checker.sv]
// Checker for the biquad cascade: watches the input, output and configuration
// ports, predicts each filtered sample and compares it with the block's result.
// Depends on bqc_pkg for the word layout, operation codes, config indexes and PSHIFT.
module biquad_cascade_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic signed [23:0] i_sample_in,
    input  logic               i_end_of_block,
    input  logic [5:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [23:0] i_sample_out,
    input  logic               i_end_of_block_out,
    input  logic               i_saturated,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bqc_pkg::*;

    localparam int STAGES = 8;
    localparam int SW     = 24;
    localparam int CW     = 32;
    localparam int FRAC   = SW + CW - 16;
    localparam int DW     = FRAC + 8;
    localparam int YSH    = FRAC - (SW - 1);
    localparam int GSH    = CW - 3;
    localparam int WORDS  = STAGES * WORDS_PER_STAGE;

    typedef struct packed {
        logic [23:0] sample;
        logic        eob;
        logic        sat;
    } t_filt_res;

    longint     coef_mem [WORDS];
    longint     dly [2*STAGES];
    logic [3:0] stage_cfg;
    logic       gain_on;
    t_filt_res  awaited_outputs [$];
    int         fails = 0;

    assign o_fail_count = fails;

    function automatic longint round_off(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint scale(longint c, longint x);
        return round_off(c * x, PSHIFT);
    endfunction

    function automatic bit over(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        return (v > hi) || (v < -hi - 1);
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Runs one sample through the sections in use and advances their delay state.
    function automatic t_filt_res filter_sample(logic signed [23:0] xin, logic eob);
        longint    x, acc, y, n1, n2;
        int        used, s, base;
        logic      clip;
        t_filt_res r;
        used = int'(stage_cfg);
        if (used == 0) used = 1;
        if (used > STAGES) used = STAGES;
        x    = longint'(xin);
        clip = 1'b0;
        for (s = 0; s < used; s++) begin
            base = s * WORDS_PER_STAGE;
            acc  = scale(coef_mem[base + int'(W_B0)], x) + dly[2*s];
            y    = round_off(acc, YSH);
            clip |= over(y, SW);
            y    = clamp(y, SW);
            n1   = scale(coef_mem[base + int'(W_B1)], x)
                   + scale(coef_mem[base + int'(W_A1)], y) + dly[2*s + 1];
            n2   = scale(coef_mem[base + int'(W_B2)], x)
                   + scale(coef_mem[base + int'(W_A2)], y);
            clip |= over(n1, DW) | over(n2, DW);
            dly[2*s]     = clamp(n1, DW);
            dly[2*s + 1] = clamp(n2, DW);
            // The delay update above used the unscaled section output.
            if (gain_on) begin
                y = round_off(y * coef_mem[base + int'(W_GAIN)], GSH);
                clip |= over(y, SW);
                y = clamp(y, SW);
            end
            x = y;
        end
        r.sample = x[23:0];
        r.eob    = eob;
        r.sat    = clip;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_filt_res want;
        int        i;
        if (!i_rst_n) begin
            for (i = 0; i < 2*STAGES; i++) dly[i] = 0;
            for (i = 0; i < WORDS; i++) coef_mem[i] = 0;
            stage_cfg = 4'd1;
            gain_on   = 1'b0;
            awaited_outputs.delete();
            o_pending <= 0;
        end else begin
            // Results are checked before new transactions are predicted.
            if (i_out_valid && !i_out_stall) begin
                if (awaited_outputs.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected output: sample %0d eob %0b sat %0b",
                                 i_sample_out, i_end_of_block_out, i_saturated);
                end else begin
                    want = awaited_outputs.pop_front();
                    if (want.sample !== i_sample_out || want.eob !== i_end_of_block_out
                        || want.sat !== i_saturated) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $signed(want.sample), want.eob, want.sat,
                                     i_sample_out, i_end_of_block_out, i_saturated);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_COEF) begin
                    if (i_coef_index < WORDS)
                        coef_mem[i_coef_index] = longint'(i_coef_value);
                end else begin
                    awaited_outputs.push_back(filter_sample(i_sample_in, i_end_of_block));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_NUM_STAGES) stage_cfg = i_cfg_wdata;
                else gain_on = i_cfg_wdata[0];
            end
            o_pending <= awaited_outputs.size();
        end
    end

endmodule

[tb/biquad_cascade_df2t_gain_tb.sv]
// Top of the biquad cascade testbench: clock, reset, stimulus, receiver stalls
// and the verdict. Depends on bqc_pkg, biquad_cascade_df2t_gain and
// biquad_cascade_checker.
module biquad_cascade_df2t_gain_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bqc_pkg::*;

    localparam int          LIMIT       = 1000000;
    localparam int          SETTLE      = 80;
    localparam int          HOLD_LEN    = 1500;
    localparam int          HOLD_AT     = 500;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 210;
    localparam logic [23:0] SMP_MAX     = 24'h7FFFFF;
    localparam logic [23:0] SMP_MIN     = 24'h800000;
    localparam logic [31:0] Q_ONE       = 32'h2000_0000;
    localparam logic [31:0] Q_HALF      = 32'h1000_0000;
    localparam logic [31:0] Q_QUARTER   = 32'h0800_0000;
    localparam logic [31:0] COEF_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN    = 32'h8000_0000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_op           = OP_FILTER;
    logic [23:0] i_sample_in    = '0;
    logic        i_end_of_block = 1'b0;
    logic [5:0]  i_coef_index   = '0;
    logic [31:0] i_coef_value   = '0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_index    = CFG_NUM_STAGES;
    logic [3:0]  i_cfg_wdata    = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [23:0] o_sample_out;
    logic        o_end_of_block_out;
    logic        o_saturated;

    int          fail_count;
    int          pending_results;
    int          results_seen = 0;
    bit          quiet        = 1'b0;

    biquad_cascade_df2t_gain uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_sample_in        (i_sample_in),
        .i_end_of_block     (i_end_of_block),
        .i_coef_index       (i_coef_index),
        .i_coef_value       (i_coef_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_sample_out       (o_sample_out),
        .o_end_of_block_out (o_end_of_block_out),
        .o_saturated        (o_saturated),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    biquad_cascade_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_sample_in        (i_sample_in),
        .i_end_of_block     (i_end_of_block),
        .i_coef_index       (i_coef_index),
        .i_coef_value       (i_coef_value),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_sample_out       (o_sample_out),
        .i_end_of_block_out (o_end_of_block_out),
        .i_saturated        (o_saturated),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_fail_count       (fail_count),
        .o_pending          (pending_results)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("biquad_cascade_df2t_gain test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) results_seen <= results_seen + 1;
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 27);
            end
        end
    end

    function automatic logic [31:0] rand_span(int unsigned half);
        return $urandom_range(2*half - 1) - half;
    endfunction

    // Table address of one word of one section.
    function automatic logic [5:0] coef_addr(int st, logic [2:0] w);
        return 6'(st * WORDS_PER_STAGE + int'(w));
    endfunction

    // Offers one transaction and holds it until the block takes it.
    task automatic send_item(logic op, logic [23:0] smp, logic eob, logic [5:0] idx,
                             logic [31:0] val);
        while (!quiet && $urandom_range(99) < 27) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_sample_in    <= smp;
        i_end_of_block <= eob;
        i_coef_index   <= idx;
        i_coef_value   <= val;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_sample(logic [23:0] smp, logic eob);
        send_item(OP_FILTER, smp, eob, 6'($urandom), $urandom);
    endtask

    task automatic send_coef(logic [5:0] idx, logic [31:0] val);
        send_item(OP_COEF, 24'($urandom), 1'($urandom), idx, val);
    endtask

    // Drops valid, waits for every awaited result, then idles for the SETTLE period.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apply_settings(logic [3:0] ns, logic ge);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NUM_STAGES;
        i_cfg_wdata <= ns;
        @(negedge i_clk);
        i_cfg_index <= CFG_GAIN_ENABLE;
        i_cfg_wdata <= {3'b000, ge};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random(output bit counted);
        int unsigned pick;
        logic [5:0]  idx;
        logic [2:0]  word;
        logic [31:0] val;
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 70) begin
            if (pick < 4) send_sample(pick[0] ? SMP_MAX : SMP_MIN, 1'($urandom));
            else if (pick < 25) send_sample(24'($urandom), 1'($urandom));
            else send_sample(24'(rand_span(1 << 16)), 1'($urandom));
        end else if (pick < 95) begin
            idx  = 6'($urandom_range(47));
            word = 3'(idx % WORDS_PER_STAGE);
            if (pick < 75) begin
                val = $urandom;
            end else begin
                case (word)
                    W_A1:    val = rand_span(1 << 29);
                    W_GAIN:  val = rand_span(1 << 30);
                    default: val = rand_span(1 << 28);
                endcase
            end
            send_coef(idx, val);
        end else begin
            // Writes past the table are dropped by the block.
            send_coef(6'($urandom_range(63, 48)), $urandom);
            counted = 1'b0;
        end
    endtask

    initial begin : stimulus
        int         p, s, n;
        bit         counted;
        logic [3:0] ns;
        logic       ge;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        apply_settings(4'd1, 1'b0);

        // Every section gets a mild low-pass so no unwritten word is ever read.
        for (s = 0; s < 8; s++) begin
            send_coef(coef_addr(s, W_B0), Q_QUARTER);
            send_coef(coef_addr(s, W_B1), Q_HALF);
            send_coef(coef_addr(s, W_B2), Q_QUARTER);
            send_coef(coef_addr(s, W_A1), Q_HALF);
            send_coef(coef_addr(s, W_A2), -Q_QUARTER);
            send_coef(coef_addr(s, W_GAIN), Q_ONE);
        end

        // Directed: sample extremes, coefficient extremes and dropped writes.
        send_sample(24'd0, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b0);
        send_sample(24'd1, 1'b1);
        send_coef(coef_addr(0, W_B0), COEF_MAX);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_coef(coef_addr(0, W_B0), COEF_MIN);
        send_sample(SMP_MAX, 1'b0);
        send_coef(6'd63, $urandom);
        send_coef(6'd48, $urandom);
        send_coef(coef_addr(0, W_B0), Q_QUARTER);
        send_sample(24'hFFFFFF, 1'b0);

        settle_block();
        apply_settings(4'd8, 1'b1);
        send_coef(coef_addr(7, W_GAIN), COEF_MAX);
        send_sample(SMP_MAX, 1'b0);
        send_coef(coef_addr(7, W_GAIN), COEF_MIN);
        send_sample(SMP_MIN, 1'b1);
        send_coef(coef_addr(7, W_GAIN), Q_ONE);
        send_sample(24'd12345, 1'b0);

        // A stage count of zero runs one section, anything above eight runs eight.
        settle_block();
        apply_settings(4'd0, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);

        settle_block();
        apply_settings(4'd15, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample(24'd0, 1'b0);

        for (p = 0; p < PHASES; p++) begin
            settle_block();
            case (p)
                0:       begin ns = 4'd8;  ge = 1'b0; end
                1:       begin ns = 4'd1;  ge = 1'b1; end
                2:       begin ns = 4'd15; ge = 1'b1; end
                default: begin ns = 4'($urandom_range(15)); ge = 1'($urandom_range(1)); end
            endcase
            apply_settings(ns, ge);
            quiet = (p == 4);
            n = 0;
            while (n < PHASE_ITEMS) begin
                send_random(counted);
                if (counted) n++;
            end
        end
        quiet = 1'b0;

        settle_block();
        if (fail_count == 0)
            $display("biquad_cascade_df2t_gain test passed");
        else
            $display("biquad_cascade_df2t_gain test failed");
        $finish;
    end

endmodule
